[sv/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and weight table of the cubic B-spline smoother.
// ----------------------------------------------------------------------------
package cbs_pkg;

   // coordinate and point bookkeeping
   localparam int COORD_W   = 32;
   localparam int TAPS      = 4;
   localparam int WIN_DEPTH = 3;
   localparam logic [2:0] SEEN_FULL = 3'd4;

   // command queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // window indexes inside one command: two start windows, main, two end windows
   localparam logic [2:0] WIN_FIRST = 3'd0;
   localparam logic [2:0] WIN_MAIN  = 3'd2;
   localparam logic [2:0] WIN_LAST  = 3'd4;
   localparam logic [1:0] PHASE_LAST = 2'd3;

   // datapath widths
   localparam int PROD_W      = 40;   // 32-bit point times weight up to 256
   localparam int SUM_W       = 42;
   localparam int ROUND_SHIFT = 7;    // divide by 128 first, then by 3
   localparam int U_W         = 34;
   localparam int HI_W        = 16;
   localparam int LO_W        = 18;
   localparam int QHI_W       = 14;

   // rounding half (192) plus an offset of 3 * 2^38 that keeps the sum positive
   localparam logic [SUM_W-1:0] SUM_BIAS = 42'h0C0_0000_00C0;

   // reciprocals of 3: ceil(2^18 / 3) and ceil(2^22 / 3)
   localparam logic [16:0] RECIP_HI       = 17'd87382;
   localparam int          RECIP_HI_SHIFT = 18;
   localparam logic [20:0] RECIP_LO       = 21'd1398102;
   localparam int          RECIP_LO_SHIFT = 22;

   // removes the positive offset again
   localparam logic [COORD_W-1:0] SIGN_FLIP = 32'h8000_0000;

   // one command from the front: window plus new point
   typedef struct packed {
      logic [TAPS-1:0][COORD_W-1:0] px;
      logic [TAPS-1:0][COORD_W-1:0] py;
      logic                         first;
      logic                         last;
      logic                         err;
   } cmd_type;

   typedef struct packed {
      logic run_last;
      logic curve_done;
      logic too_short;
   } tag_type;

   // one curve sample issued by the sequencer
   typedef struct packed {
      logic                         valid;
      logic [1:0]                   phase;
      logic [TAPS-1:0][COORD_W-1:0] px;
      logic [TAPS-1:0][COORD_W-1:0] py;
      tag_type                      tag;
   } sample_type;

   // integer basis weights, scaled by 384, for t = 0, 1/4, 1/2, 3/4
   function automatic logic [8:0] bspline_weight(input logic [1:0] phase,
                                                 input logic [1:0] tap);
      logic [8:0] w;
      case ({phase, tap})
         4'b00_00: w = 9'd64;
         4'b00_01: w = 9'd256;
         4'b00_10: w = 9'd64;
         4'b00_11: w = 9'd0;
         4'b01_00: w = 9'd27;
         4'b01_01: w = 9'd235;
         4'b01_10: w = 9'd121;
         4'b01_11: w = 9'd1;
         4'b10_00: w = 9'd8;
         4'b10_01: w = 9'd184;
         4'b10_10: w = 9'd184;
         4'b10_11: w = 9'd8;
         4'b11_00: w = 9'd1;
         4'b11_01: w = 9'd121;
         4'b11_10: w = 9'd235;
         4'b11_11: w = 9'd27;
         default:  w = 9'd0;
      endcase
      return w;
   endfunction

endpackage

[sv/cbs_front.sv]
// ----------------------------------------------------------------------------
// cbs_front
// Takes control points, keeps the last three and counts the path length.
// Hands the queue one command per window-producing point or short path end.
// ----------------------------------------------------------------------------
module cbs_front import cbs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      req_path_end,
   input  logic                      q_full,
   output logic                      q_push,
   output cmd_type                   q_cmd
);

   logic [2:0]         seen_ff, seen_in;
   logic [COORD_W-1:0] winx_ff [WIN_DEPTH];
   logic [COORD_W-1:0] winy_ff [WIN_DEPTH];
   logic               accept;
   logic               short_path;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign short_path = seen_ff < 3'(WIN_DEPTH);

   // command for the queue
   always_comb begin
      q_cmd.px    = {req_point_x, winx_ff[2], winx_ff[1], winx_ff[0]};
      q_cmd.py    = {req_point_y, winy_ff[2], winy_ff[1], winy_ff[0]};
      q_cmd.first = seen_ff == 3'(WIN_DEPTH);
      q_cmd.last  = req_path_end;
      q_cmd.err   = short_path;
      q_push      = accept && (!short_path || req_path_end);
   end

   // path length, saturating
   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_path_end) begin
            seen_in = 3'd0;
         end else if (short_path) begin
            seen_in = seen_ff + 3'd1;
         end else begin
            seen_in = SEEN_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 3'd0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // point window, oldest first
   always_ff @(posedge clock) begin
      if (accept) begin
         winx_ff[0] <= winx_ff[1];
         winx_ff[1] <= winx_ff[2];
         winx_ff[2] <= req_point_x;
         winy_ff[0] <= winy_ff[1];
         winy_ff[1] <= winy_ff[2];
         winy_ff[2] <= req_point_y;
      end
   end

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_FULL) else $error("point count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command pushed into full queue");

   a_err_end: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_cmd.err) |-> q_cmd.last)
      else $error("short-path command without path end");

endmodule

[sv/cbs_queue.sv]
// ----------------------------------------------------------------------------
// cbs_queue
// Two-entry command queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module cbs_queue import cbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

[sv/cbs_seq.sv]
// ----------------------------------------------------------------------------
// cbs_seq
// Expands a command into its windows: one curve sample a cycle unless stalled.
// The four-point window slides in place; end windows repeat the last point.
// ----------------------------------------------------------------------------
module cbs_seq import cbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output sample_type smp
);

   logic                         busy_ff, busy_in;
   logic                         err_ff, err_in;
   logic                         last_ff, last_in;
   logic [2:0]                   k_ff, k_in;
   logic [1:0]                   j_ff, j_in;
   logic [TAPS-1:0][COORD_W-1:0] winx_ff, winx_in;
   logic [TAPS-1:0][COORD_W-1:0] winy_ff, winy_in;
   logic [COORD_W-1:0]           q2x_ff, q2x_in, q2y_ff, q2y_in;
   logic [COORD_W-1:0]           q3x_ff, q3x_in, q3y_ff, q3y_in;
   logic [2:0]                   k_end;
   logic                         finishing;
   logic                         load;

   assign k_end     = last_ff ? WIN_LAST : WIN_MAIN;
   assign finishing = busy_ff && (j_ff == PHASE_LAST) && (err_ff || k_ff == k_end);
   assign load      = advance && cmd_valid && (!busy_ff || finishing);
   assign cmd_pop   = load;

   // sample toward the evaluator
   always_comb begin
      smp.valid          = busy_ff;
      smp.phase          = j_ff;
      smp.px             = winx_ff;
      smp.py             = winy_ff;
      smp.tag.run_last   = finishing;
      smp.tag.curve_done = finishing && (last_ff || err_ff);
      smp.tag.too_short  = err_ff;
   end

   // window and sample sequencing
   always_comb begin
      busy_in = busy_ff;
      err_in  = err_ff;
      last_in = last_ff;
      k_in    = k_ff;
      j_in    = j_ff;
      winx_in = winx_ff;
      winy_in = winy_ff;
      q2x_in  = q2x_ff;
      q2y_in  = q2y_ff;
      q3x_in  = q3x_ff;
      q3y_in  = q3y_ff;
      if (load) begin
         busy_in = 1'b1;
         err_in  = cmd.err;
         last_in = cmd.last;
         j_in    = cmd.err ? PHASE_LAST : 2'd0;
         k_in    = cmd.first ? WIN_FIRST : WIN_MAIN;
         q2x_in  = cmd.px[2];
         q2y_in  = cmd.py[2];
         q3x_in  = cmd.px[3];
         q3y_in  = cmd.py[3];
         if (cmd.first) begin
            winx_in = {cmd.px[1], cmd.px[0], cmd.px[0], cmd.px[0]};
            winy_in = {cmd.py[1], cmd.py[0], cmd.py[0], cmd.py[0]};
         end else begin
            winx_in = cmd.px;
            winy_in = cmd.py;
         end
      end else if (advance && finishing) begin
         busy_in = 1'b0;
      end else if (advance && busy_ff) begin
         j_in = j_ff + 2'd1;
         if (j_ff == PHASE_LAST) begin
            k_in = k_ff + 3'd1;
            // after the first start window the next point is P2, otherwise Pn
            if (k_ff == WIN_FIRST) begin
               winx_in = {q2x_ff, winx_ff[3:1]};
               winy_in = {q2y_ff, winy_ff[3:1]};
            end else begin
               winx_in = {q3x_ff, winx_ff[3:1]};
               winy_in = {q3y_ff, winy_ff[3:1]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         err_ff  <= 1'b0;
         last_ff <= 1'b0;
         k_ff    <= WIN_MAIN;
         j_ff    <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         err_ff  <= err_in;
         last_ff <= last_in;
         k_ff    <= k_in;
         j_ff    <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      winx_ff <= winx_in;
      winy_ff <= winy_in;
      q2x_ff  <= q2x_in;
      q2y_ff  <= q2y_in;
      q3x_ff  <= q3x_in;
      q3y_ff  <= q3y_in;
   end

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && err_ff) |-> j_ff == PHASE_LAST)
      else $error("short-path word not issued as a single sample");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> k_ff <= k_end) else $error("window index past end");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(j_ff) && $stable(k_ff) && $stable(busy_ff))
      else $error("sequencer moved while stalled");

endmodule

[sv/cbs_eval.sv]
// ----------------------------------------------------------------------------
// cbs_eval
// Four-stage evaluation pipeline: weighted products, sum with rounding bias,
// then divide by 3 in two reciprocal steps. The last stage is the rsp register.
// ----------------------------------------------------------------------------
module cbs_eval import cbs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  sample_type                smp,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_curve_x,
   output logic signed [COORD_W-1:0] rsp_curve_y,
   output logic                      rsp_run_last,
   output logic                      rsp_curve_done,
   output logic                      rsp_too_short
);

   // stage valids and tags
   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   logic    v1_in, v2_in, v3_in, v4_in;
   tag_type t1_ff, t2_ff, t3_ff, t4_ff;
   tag_type t1_in, t2_in, t3_in, t4_in;

   // payload per coordinate, index 0 is x and 1 is y
   logic [1:0][TAPS-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [1:0][U_W-1:0]              u_ff, u_in;
   logic [1:0][QHI_W-1:0]            qa_ff, qa_in;
   logic [1:0][1:0]                  ra_ff, ra_in;
   logic [1:0][LO_W-1:0]             b_ff, b_in;
   logic [1:0][COORD_W-1:0]          res_ff, res_in;
   logic [1:0][TAPS-1:0][COORD_W-1:0] pts;

   // whole pipe holds while a word waits at the output
   assign advance = !(v4_ff && rsp_stall);
   assign pts     = {smp.py, smp.px};

   function automatic logic [PROD_W-1:0] scale_tap(input logic [COORD_W-1:0] p,
                                                   input logic [8:0] w);
      logic signed [SUM_W-1:0] full;
      full = $signed(p) * $signed({1'b0, w});
      return full[PROD_W-1:0];
   endfunction

   function automatic logic [U_W-1:0] biased_sum(input logic [TAPS-1:0][PROD_W-1:0] pr);
      logic [SUM_W-1:0] acc;
      acc = SUM_BIAS;
      for (int i = 0; i < TAPS; i++) begin
         acc = acc + {{(SUM_W-PROD_W){pr[i][PROD_W-1]}}, pr[i]};
      end
      return acc[ROUND_SHIFT +: U_W];
   endfunction

   // quotient and remainder of the high part by 3
   function automatic logic [QHI_W+1:0] div3_hi(input logic [HI_W-1:0] a);
      logic [HI_W+16:0] m;
      logic [QHI_W-1:0] q;
      logic [HI_W-1:0]  r;
      m = (HI_W+17)'(a) * (HI_W+17)'(RECIP_HI);
      q = m[RECIP_HI_SHIFT +: QHI_W];
      r = a - HI_W'(q) * HI_W'(3);
      return {q, r[1:0]};
   endfunction

   function automatic logic [LO_W-1:0] div3_lo(input logic [LO_W+1:0] n);
      logic [LO_W+22:0] m;
      m = (LO_W+23)'(n) * (LO_W+23)'(RECIP_LO);
      return m[RECIP_LO_SHIFT +: LO_W];
   endfunction

   // next values of every stage
   always_comb begin
      v1_in   = smp.valid;
      v2_in   = v1_ff;
      v3_in   = v2_ff;
      v4_in   = v3_ff;
      t1_in   = smp.tag;
      t2_in   = t1_ff;
      t3_in   = t2_ff;
      t4_in   = t3_ff;
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < TAPS; i++) begin
            prod_in[c][i] = scale_tap(pts[c][i], bspline_weight(smp.phase, 2'(i)));
         end
         u_in[c] = biased_sum(prod_ff[c]);
         {qa_in[c], ra_in[c]} = div3_hi(u_ff[c][U_W-1 -: HI_W]);
         b_in[c] = u_ff[c][LO_W-1:0];
         res_in[c] = t3_ff.too_short ? '0
                   : {qa_ff[c], div3_lo({ra_ff[c], b_ff[c]})} ^ SIGN_FLIP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         t4_ff   <= t4_in;
         prod_ff <= prod_in;
         u_ff    <= u_in;
         qa_ff   <= qa_in;
         ra_ff   <= ra_in;
         b_ff    <= b_in;
         res_ff  <= res_in;
      end
   end

   // result word
   assign rsp_valid      = v4_ff;
   assign rsp_curve_x    = $signed(res_ff[0]);
   assign rsp_curve_y    = $signed(res_ff[1]);
   assign rsp_run_last   = t4_ff.run_last;
   assign rsp_curve_done = t4_ff.curve_done;
   assign rsp_too_short  = t4_ff.too_short;

   a_short_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_short) |->
         rsp_run_last && rsp_curve_done && rsp_curve_x == '0 && rsp_curve_y == '0)
      else $error("short-path word malformed");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_curve_done) |-> rsp_run_last)
      else $error("curve end without run end");

   // short-path words carry no real points, so their remainder is not checked
   a_remainder: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !t3_ff.too_short) |-> ra_ff[0] != 2'd3 && ra_ff[1] != 2'd3)
      else $error("divide-by-3 remainder out of range");

endmodule

[sv/cubic_bspline_path_smoother_top.sv]
// ----------------------------------------------------------------------------
// cubic_bspline_path_smoother_top
// Uniform cubic B-spline smoother: control points in, four curve points per
// segment out at t = 0, 1/4, 1/2, 3/4, ends padded by the first/last point.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  point_x, point_y, path_end
//   rsp      out  rsp_valid/rsp_stall  curve_x, curve_y, run_last,
//                                      curve_done, too_short
//
// One curve word per cycle while rsp is not stalled: four words per point in
// steady state, twelve for the fourth point of a path, eight more for the
// closing point and one for a short path. The sequencer, which issues one
// sample a cycle, sets the word rate.
// Synchronous reset clears the point count, the queue and all pipeline valids.
// A two-command queue lets req keep taking points while rsp is stalled;
// req_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module cubic_bspline_path_smoother_top import cbs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      req_path_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_curve_x,
   output logic signed [COORD_W-1:0] rsp_curve_y,
   output logic                      rsp_run_last,
   output logic                      rsp_curve_done,
   output logic                      rsp_too_short
);

   logic       q_full;
   logic       q_push;
   cmd_type    q_cmd;
   logic       head_valid;
   cmd_type    head_cmd;
   logic       cmd_pop;
   logic       advance;
   sample_type smp;

   cbs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_path_end (req_path_end),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (q_cmd)
   );

   cbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   cbs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .smp       (smp)
   );

   cbs_eval u_eval (
      .clock          (clock),
      .reset          (reset),
      .smp            (smp),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_curve_x    (rsp_curve_x),
      .rsp_curve_y    (rsp_curve_y),
      .rsp_run_last   (rsp_run_last),
      .rsp_curve_done (rsp_curve_done),
      .rsp_too_short  (rsp_too_short)
   );

endmodule
